>>> rtl/core/blz_pkg.sv
// Shared types and constants of the backward LZ decoder.
// No dependencies; used by the decoder core and its checker.
package blz_pkg;

  // Sizes
  localparam int unsigned HIST_DEPTH = 8192;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned CNT_W      = 26;
  localparam int unsigned LEN_W      = 5;

  // Token constants
  localparam logic [3:0] TOKENS_PER_FLAG = 4'd8;
  localparam logic [3:0] MATCH_BIAS      = 4'd3;

  // Sequencer states (one-hot)
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_COPY = 2'b10
  } seq_state_t;

  // Run status kept between requests
  typedef enum logic [1:0] {
    HALT_RUN  = 2'd0,
    HALT_DONE = 2'd1,
    HALT_OVR  = 2'd2,
    HALT_DIST = 2'd3
  } halt_t;

  // Status code carried with each result
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OVR  = 2'd1,
    STAT_DIST = 2'd2
  } status_t;

endpackage

>>> rtl/core/backward_lz_decoder_top.sv
// Backward LZ decoder core: flag/token parser, history memory and copy sequencer.
// Depends on blz_pkg.
//
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   in_tdata[7:0] = in_byte
// out_     out  out_tvalid/out_tready out_tdata[7:0] = out_byte, out_tlast = run_last,
//                                     out_tuser[2:0] = {status, finished}
// cfg_     in   cfg_we                cfg_wdata[25:0] = out_length
//
// A flag byte, a match high byte or a literal is decoded as it is taken. For a match, the
// low byte issues the first history read, then the copy emits one byte per cycle, while the
// output slot is free, through the single read/write port pair of the history memory.
// Input is not taken while a match is copying or while a result waits unaccepted.
// Reset (synchronous, active low) clears control state only; history is not cleared.
module backward_lz_decoder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] in_byte
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] out_byte
  output logic                       out_tlast,
  output logic [2:0]                 out_tuser,  // [0] finished, [2:1] status
  input  logic                       cfg_we,
  input  logic [blz_pkg::CNT_W-1:0]  cfg_wdata
);

  // Control and context registers
  blz_pkg::seq_state_t          state_r, state_nxt;
  blz_pkg::halt_t               halt_r, halt_nxt;
  logic [7:0]                   flag_r, flag_nxt;
  logic [3:0]                   tok_r, tok_nxt;
  logic                         phase_r, phase_nxt;
  logic [7:0]                   mhigh_r, mhigh_nxt;
  logic [blz_pkg::CNT_W-1:0]    prod_r, prod_nxt;
  logic [blz_pkg::CNT_W-1:0]    olen_r;
  logic [blz_pkg::HIST_AW-1:0]  wp_r, wp_nxt;
  logic [blz_pkg::HIST_AW-1:0]  src_r, src_nxt;
  logic [blz_pkg::LEN_W-1:0]    cnt_r, cnt_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [7:0]                   out_data_r, out_data_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_fin_r, out_fin_nxt;
  blz_pkg::status_t             out_stat_r, out_stat_nxt;

  // History memory
  logic [7:0]                   hist_mem [blz_pkg::HIST_DEPTH];
  logic [7:0]                   rdata_r;
  logic                         mem_we, mem_re;
  logic [7:0]                   mem_wdata;
  logic [blz_pkg::HIST_AW-1:0]  mem_raddr;

  // Decode helpers
  logic                         out_free, in_fire, out_load;
  logic [blz_pkg::CNT_W-1:0]    remaining, prod_inc;
  logic [blz_pkg::LEN_W-1:0]    match_len;
  logic [blz_pkg::HIST_AW-1:0]  match_dist;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == blz_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign remaining  = olen_r - prod_r;
  assign prod_inc   = prod_r + blz_pkg::CNT_W'(1);
  assign match_len  = {1'b0, mhigh_r[7:4]} + blz_pkg::LEN_W'(blz_pkg::MATCH_BIAS);
  assign match_dist = blz_pkg::HIST_AW'({mhigh_r[3:0], in_tdata})
                      + blz_pkg::HIST_AW'(blz_pkg::MATCH_BIAS);

  // Sequencer and token parser
  always_comb begin
    state_nxt    = state_r;
    halt_nxt     = halt_r;
    flag_nxt     = flag_r;
    tok_nxt      = tok_r;
    phase_nxt    = phase_r;
    mhigh_nxt    = mhigh_r;
    prod_nxt     = prod_r;
    wp_nxt       = wp_r;
    src_nxt      = src_r;
    cnt_nxt      = cnt_r;
    out_load     = 1'b0;
    out_data_nxt = 8'd0;
    out_last_nxt = 1'b0;
    out_fin_nxt  = 1'b0;
    out_stat_nxt = blz_pkg::STAT_OK;
    mem_we       = 1'b0;
    mem_wdata    = in_tdata;
    mem_re       = 1'b0;
    mem_raddr    = src_r;

    unique case (state_r)
      blz_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (halt_r)
            blz_pkg::HALT_DONE: begin
              // drop the request
            end
            blz_pkg::HALT_OVR: begin
              out_load     = 1'b1;
              out_last_nxt = 1'b1;
              out_stat_nxt = blz_pkg::STAT_OVR;
            end
            blz_pkg::HALT_DIST: begin
              out_load     = 1'b1;
              out_last_nxt = 1'b1;
              out_stat_nxt = blz_pkg::STAT_DIST;
            end
            default: begin
              if (prod_r >= olen_r) begin
                halt_nxt = blz_pkg::HALT_DONE;
              end else if (tok_r == 4'd0) begin
                // new flag byte
                flag_nxt  = in_tdata;
                tok_nxt   = blz_pkg::TOKENS_PER_FLAG;
                phase_nxt = 1'b0;
              end else if (!flag_r[7]) begin
                // literal
                mem_we       = 1'b1;
                wp_nxt       = wp_r + blz_pkg::HIST_AW'(1);
                prod_nxt     = prod_inc;
                out_load     = 1'b1;
                out_data_nxt = in_tdata;
                out_last_nxt = 1'b1;
                flag_nxt     = {flag_r[6:0], 1'b0};
                tok_nxt      = tok_r - 4'd1;
                if (prod_inc >= olen_r) begin
                  out_fin_nxt = 1'b1;
                  halt_nxt    = blz_pkg::HALT_DONE;
                end
              end else if (!phase_r) begin
                // match high byte
                mhigh_nxt = in_tdata;
                phase_nxt = 1'b1;
              end else begin
                // match low byte: check, then start the copy
                phase_nxt = 1'b0;
                if (blz_pkg::CNT_W'(match_len) > remaining) begin
                  halt_nxt     = blz_pkg::HALT_OVR;
                  out_load     = 1'b1;
                  out_last_nxt = 1'b1;
                  out_stat_nxt = blz_pkg::STAT_OVR;
                end else if (blz_pkg::CNT_W'(match_dist) > prod_r) begin
                  halt_nxt     = blz_pkg::HALT_DIST;
                  out_load     = 1'b1;
                  out_last_nxt = 1'b1;
                  out_stat_nxt = blz_pkg::STAT_DIST;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = wp_r - match_dist;
                  src_nxt   = wp_r - match_dist + blz_pkg::HIST_AW'(1);
                  cnt_nxt   = match_len;
                  flag_nxt  = {flag_r[6:0], 1'b0};
                  tok_nxt   = tok_r - 4'd1;
                  state_nxt = blz_pkg::ST_COPY;
                end
              end
            end
          endcase
        end
      end
      blz_pkg::ST_COPY: begin
        // emit one copied byte per free output slot, prefetch the next
        if (out_free) begin
          mem_we       = 1'b1;
          mem_wdata    = rdata_r;
          wp_nxt       = wp_r + blz_pkg::HIST_AW'(1);
          prod_nxt     = prod_inc;
          cnt_nxt      = cnt_r - blz_pkg::LEN_W'(1);
          out_load     = 1'b1;
          out_data_nxt = rdata_r;
          if (cnt_r == blz_pkg::LEN_W'(1)) begin
            out_last_nxt = 1'b1;
            state_nxt    = blz_pkg::ST_IDLE;
            if (prod_inc >= olen_r) begin
              out_fin_nxt = 1'b1;
              halt_nxt    = blz_pkg::HALT_DONE;
            end
          end else begin
            mem_re  = 1'b1;
            src_nxt = src_r + blz_pkg::HIST_AW'(1);
          end
        end
      end
      default: begin
        state_nxt = blz_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: load a new result or drop the taken one
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blz_pkg::ST_IDLE;
      halt_r      <= blz_pkg::HALT_RUN;
      flag_r      <= 8'd0;
      tok_r       <= 4'd0;
      phase_r     <= 1'b0;
      mhigh_r     <= 8'd0;
      prod_r      <= '0;
      olen_r      <= '0;
      wp_r        <= '0;
      src_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      halt_r      <= halt_nxt;
      flag_r      <= flag_nxt;
      tok_r       <= tok_nxt;
      phase_r     <= phase_nxt;
      mhigh_r     <= mhigh_nxt;
      prod_r      <= prod_nxt;
      wp_r        <= wp_nxt;
      src_r       <= src_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        olen_r <= cfg_wdata;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
      out_fin_r  <= out_fin_nxt;
      out_stat_r <= out_stat_nxt;
    end
  end

  // History memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wp_r] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= hist_mem[mem_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_stat_r, out_fin_r};

endmodule

>>> rtl/core/blz_checker.sv
// Port-level checker for the backward LZ decoder, bound to its top level.
// Depends on blz_pkg and backward_lz_decoder_top.
module blz_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [2:0] out_tuser
);

  // A finished mark only rides on the last result of a request
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("finished without run_last");

  // Error results carry a zero byte and close the request
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] != blz_pkg::STAT_OK) |-> out_tlast && (out_tdata == 8'd0))
    else $error("malformed error result");

  // No new request while a result is stalled
  a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  // Nothing follows the finishing result
  a_quiet_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[0] |=> !out_tvalid)
    else $error("result after finish");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind backward_lz_decoder_top blz_checker u_blz_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

>>> dv/backward_lz_decoder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the backward LZ decoder: directed token rows, then random
// flag groups, predicted by a local decode model. Depends on blz_pkg and the decoder top.
module backward_lz_decoder_top_tb;

  localparam int unsigned CYCLE_LIMIT = 1_200_000;
  localparam int unsigned MAX_DIST    = 4098;
  localparam logic [blz_pkg::CNT_W-1:0] LEN_MAX = 26'h3FFFFFF;

  // One decoded byte as it leaves the block
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             fin;
    blz_pkg::status_t st;
  } blz_res_t;

  // How a stimulus row is checked: by the decode model or by a fixed expectation
  typedef enum logic [2:0] {
    ROW_MODEL,     // results come from the decode model
    ROW_QUIET,     // flag byte, match high byte or ignored byte: no result
    ROW_LIT,       // literal: the byte comes back as it is
    ROW_ERR_OVR,   // one length-overrun result
    ROW_ERR_DIST   // one distance result
  } row_kind_t;

  typedef struct packed {
    logic [7:0] data;
    row_kind_t  kind;
  } row_t;

  // Opening rows: literal extremes, then shortest, longest and overlapping matches
  localparam row_t OPEN_ROWS [22] = '{
    '{8'h00, ROW_QUIET},                     // flag: eight literals
    '{8'h00, ROW_LIT}, '{8'hFF, ROW_LIT}, '{8'h55, ROW_LIT}, '{8'hAA, ROW_LIT},
    '{8'h01, ROW_LIT}, '{8'h80, ROW_LIT}, '{8'h7F, ROW_LIT}, '{8'hFE, ROW_LIT},
    '{8'hF0, ROW_QUIET},                     // flag: four matches, four literals
    '{8'h00, ROW_QUIET}, '{8'h00, ROW_MODEL}, // length 3, distance 3
    '{8'hF0, ROW_QUIET}, '{8'h00, ROW_MODEL}, // length 18, distance 3, overlapping
    '{8'hF0, ROW_QUIET}, '{8'h1A, ROW_MODEL}, // distance equal to bytes produced
    '{8'h50, ROW_QUIET}, '{8'h07, ROW_MODEL}, // length 8, distance 10
    '{8'h12, ROW_LIT}, '{8'h34, ROW_LIT}, '{8'hC3, ROW_LIT}, '{8'h3C, ROW_LIT}
  };

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [7:0]                in_tdata;   // [7:0] in_byte
  logic                      out_tvalid;
  logic                      out_tready;
  logic [7:0]                out_tdata;  // [7:0] out_byte
  logic                      out_tlast;
  logic [2:0]                out_tuser;  // [0] finished, [2:1] status
  logic                      cfg_we;
  logic [blz_pkg::CNT_W-1:0] cfg_wdata;

  // Decode model state
  logic [7:0]                  hist [blz_pkg::HIST_DEPTH];
  logic [7:0]                  flags;
  logic [3:0]                  tok_left;
  logic                        in_match;
  logic [7:0]                  match_hi;
  int unsigned                 produced;
  logic [blz_pkg::HIST_AW-1:0] wptr;
  blz_pkg::halt_t              halt;
  logic [blz_pkg::CNT_W-1:0]   out_len;

  blz_res_t    step_res [$];
  blz_res_t    decoded_due [$];
  blz_res_t    head;
  int unsigned err_cnt;
  int unsigned req_count;
  int unsigned res_count;
  int unsigned cycle_cnt;
  bit          quiet;
  string       tail_name;

  backward_lz_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("backward_lz_decoder_top_tb: done, errors");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Append one decoded byte to the history
  function automatic void emit_byte(input logic [7:0] v);
    hist[wptr] = v;
    wptr = wptr + 1'b1;
    produced++;
    step_res.push_back('{v, 1'b0, 1'b0, blz_pkg::STAT_OK});
  endfunction

  // Decode one compressed byte into step_res
  task automatic decode_step(input logic [7:0] b);
    int unsigned len;
    int unsigned mdist;
    step_res.delete();
    if (halt == blz_pkg::HALT_DONE) return;
    if (halt == blz_pkg::HALT_OVR || halt == blz_pkg::HALT_DIST) begin
      step_res.push_back('{8'h00, 1'b1, 1'b0,
                           (halt == blz_pkg::HALT_OVR) ? blz_pkg::STAT_OVR
                                                       : blz_pkg::STAT_DIST});
      return;
    end
    if (produced >= out_len) begin
      halt = blz_pkg::HALT_DONE;
      return;
    end
    // New flag byte
    if (tok_left == 0) begin
      flags = b;
      tok_left = blz_pkg::TOKENS_PER_FLAG;
      in_match = 1'b0;
      return;
    end
    if (!flags[7]) begin
      emit_byte(b);
    end else if (!in_match) begin
      match_hi = b;
      in_match = 1'b1;
      return;
    end else begin
      len   = match_hi[7:4] + blz_pkg::MATCH_BIAS;
      mdist = {match_hi[3:0], b} + blz_pkg::MATCH_BIAS;
      in_match = 1'b0;
      if (len > out_len - produced) begin
        halt = blz_pkg::HALT_OVR;
        step_res.push_back('{8'h00, 1'b1, 1'b0, blz_pkg::STAT_OVR});
        return;
      end
      if (mdist > produced) begin
        halt = blz_pkg::HALT_DIST;
        step_res.push_back('{8'h00, 1'b1, 1'b0, blz_pkg::STAT_DIST});
        return;
      end
      // Copy byte by byte so that overlapping matches repeat
      repeat (len) emit_byte(hist[blz_pkg::HIST_AW'(wptr - mdist)]);
    end
    flags = flags << 1;
    tok_left = tok_left - 1'b1;
    if (step_res.size() > 0) begin
      step_res[step_res.size() - 1].last = 1'b1;
      if (produced >= out_len) begin
        halt = blz_pkg::HALT_DONE;
        step_res[step_res.size() - 1].fin = 1'b1;
      end
    end
  endtask

  // Send one request, queue what it should produce, then maybe pause
  task automatic send_row(input row_t r);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= r.data;
    do @(posedge clk); while (!in_tready);
    decode_step(r.data);
    req_count++;
    case (r.kind)
      ROW_MODEL:    foreach (step_res[i]) decoded_due.push_back(step_res[i]);
      ROW_QUIET:    ;
      ROW_LIT:      decoded_due.push_back('{r.data, 1'b1, 1'b0, blz_pkg::STAT_OK});
      ROW_ERR_OVR:  decoded_due.push_back('{8'h00, 1'b1, 1'b0, blz_pkg::STAT_OVR});
      ROW_ERR_DIST: decoded_due.push_back('{8'h00, 1'b1, 1'b0, blz_pkg::STAT_DIST});
      default:      ;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all results, let the block settle, then write out_length
  task automatic write_out_len(input logic [blz_pkg::CNT_W-1:0] v);
    in_tvalid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    out_len = v;
  endtask

  // One well-formed flag group with random tokens
  task automatic send_group();
    logic [7:0]  flag;
    logic [3:0]  len_code;
    logic [11:0] offs;
    int unsigned dist_cap;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)      flag = 8'hFF;
    else if (r < 45) flag = 8'h00;
    else             flag = 8'($urandom_range(0, 255));
    send_row('{flag, ROW_QUIET});
    for (int i = 7; i >= 0; i--) begin
      if (flag[i]) begin
        r = $urandom_range(0, 99);
        if (r < 30)      len_code = 4'hF;
        else if (r < 40) len_code = 4'h0;
        else             len_code = 4'($urandom_range(0, 15));
        // Mostly short distances for overlapping copies, some far back
        dist_cap = (produced < MAX_DIST) ? produced : MAX_DIST;
        if ($urandom_range(0, 99) < 60 && dist_cap > 24) dist_cap = 24;
        offs = 12'($urandom_range(blz_pkg::MATCH_BIAS, dist_cap) - blz_pkg::MATCH_BIAS);
        send_row('{{len_code, offs[11:8]}, ROW_QUIET});
        send_row('{offs[7:0], ROW_MODEL});
      end else begin
        send_row('{8'($urandom_range(0, 255)), ROW_MODEL});
      end
    end
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_due.size() == 0) begin
        $error("unexpected result: out_byte %0h tlast %0b tuser %0h",
               out_tdata, out_tlast, out_tuser);
        err_cnt++;
      end else begin
        head = decoded_due.pop_front();
        res_count++;
        if (out_tdata !== head.data) begin
          $error("out_byte: expected %0h, got %0h", head.data, out_tdata);
          err_cnt++;
        end
        if (out_tlast !== head.last) begin
          $error("run_last: expected %0b, got %0b", head.last, out_tlast);
          err_cnt++;
        end
        if (out_tuser[0] !== head.fin) begin
          $error("finished: expected %0b, got %0b", head.fin, out_tuser[0]);
          err_cnt++;
        end
        if (out_tuser[2:1] !== head.st) begin
          $error("status: expected %0d, got %0d", head.st, out_tuser[2:1]);
          err_cnt++;
        end
      end
    end
  end

  // Receiver: ready in runs, broken by random stalls
  initial begin
    int run;
    int gap;
    out_tready <= 1'b1;
    forever begin
      run = $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    int tail_kind;
    int r;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    foreach (hist[i]) hist[i] = 8'h00;
    flags    = 8'h00;
    tok_left = 4'd0;
    in_match = 1'b0;
    match_hi = 8'h00;
    produced = 0;
    wptr     = '0;
    halt     = blz_pkg::HALT_RUN;
    out_len  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the largest output length
    write_out_len(LEN_MAX);
    foreach (OPEN_ROWS[i]) send_row(OPEN_ROWS[i]);

    // Random flag groups over several length settings, one phase with no idling
    while (req_count < 120) send_group();
    write_out_len(26'h2AAAAAA);
    quiet = 1'b1;
    while (req_count < 210) send_group();
    quiet = 1'b0;
    write_out_len(26'h1555555);
    while (req_count < 300) send_group();

    // Close the run with one terminal condition; only reset would clear it
    tail_kind = $urandom_range(0, 3);
    if (tail_kind == 3 && produced >= MAX_DIST) tail_kind = 2;
    case (tail_kind)
      0: begin
        tail_name = "finish on the last literal";
        write_out_len(blz_pkg::CNT_W'(produced + 3));
        send_row('{8'h00, ROW_QUIET});
        repeat (3) send_row('{8'($urandom_range(0, 255)), ROW_MODEL});
        repeat (3) send_row('{8'($urandom_range(0, 255)), ROW_QUIET});
      end
      1: begin
        tail_name = "output length lowered to zero";
        write_out_len('0);
        repeat (3) send_row('{8'($urandom_range(0, 255)), ROW_QUIET});
      end
      2: begin
        tail_name = "length overrun";
        write_out_len(blz_pkg::CNT_W'(produced + 5));
        send_row('{8'h80, ROW_QUIET});
        send_row('{{4'hF, 4'($urandom_range(0, 15))}, ROW_QUIET});
        send_row('{8'($urandom_range(0, 255)), ROW_ERR_OVR});
        repeat (3) send_row('{8'($urandom_range(0, 255)), ROW_ERR_OVR});
      end
      default: begin
        tail_name = "distance beyond produced";
        send_row('{8'h80, ROW_QUIET});
        send_row('{8'h0F, ROW_QUIET});
        send_row('{8'hFF, ROW_ERR_DIST});
        repeat (3) send_row('{8'($urandom_range(0, 255)), ROW_ERR_DIST});
      end
    endcase

    // Drain and settle
    in_tvalid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d requests and checked %0d results; %0d bytes decoded.",
             req_count, res_count, produced);
    $display("Run closed with %s.", tail_name);
    if (err_cnt == 0) begin
      $display("backward_lz_decoder_top_tb: done, clean");
    end else begin
      $display("backward_lz_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule
